>>> sv/rcsfd_pkg.sv
package rcsfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int CH_IDX_W  = 4;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h20;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h40;
    localparam logic [WORD_W-1:0] CSUM_INIT  = 16'hFFFF;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [CH_IDX_W-1:0] t_ch_idx;

endpackage

>>> sv/rcsfd_rx_if.sv
interface rcsfd_rx_if;

    logic               valid;
    logic               ready;
    rcsfd_pkg::t_byte   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

>>> sv/rcsfd_ch_if.sv
interface rcsfd_ch_if;

    logic               valid;
    logic               ready;
    rcsfd_pkg::t_ch_idx channel_index;
    rcsfd_pkg::t_word   channel_value;
    logic               last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last_channel, output ready);

endinterface

>>> sv/rc_serial_frame_decoder.sv
// channel   dir   payload                                       handshake
// i_rx      in    rx_byte[7:0]                                  valid/ready
// o_ch      out   channel_index[3:0] channel_value[15:0] last   valid/ready
//
// one received byte per cycle while no frame is being read out
// a good frame reads its words from the channel ram, one read port,
// one read in flight at a time, so i_rx is held off until the last word's read is issued
// a stalled o_ch holds the readout; the byte input waits meanwhile
// synchronous active-low reset returns to header hunt, ram is not cleared
module rc_serial_frame_decoder #(
    parameter int CHANNEL_COUNT = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcsfd_rx_if.sink     i_rx,
    rcsfd_ch_if.source   o_ch
);

    import rcsfd_pkg::*;

    localparam int FRAME_BYTES = 2 * CHANNEL_COUNT + 4;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int IDX_W       = $clog2(CHANNEL_COUNT);
    localparam logic [POS_W-1:0] POS_HDR0  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR1  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CSUML = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_CSUMH = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_FIRST_HI = POS_W'(3);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(CHANNEL_COUNT - 1);

    logic [POS_W-1:0] r_pos,     n_pos;
    t_word            r_csum,    n_csum;
    t_byte            r_lo,      n_lo;
    t_byte            r_cklo,    n_cklo;
    logic             r_busy,    n_busy;
    logic [IDX_W-1:0] r_rd_idx,  n_rd_idx;
    logic             r_rd_pend;
    logic [IDX_W-1:0] r_pend_idx;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    t_word            r_out_val;
    logic             r_out_last;

    logic             w_take;
    logic             w_issue;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [POS_W-1:0] w_off;
    t_word            w_rdata;
    t_byte            w_b;

    assign w_b     = i_rx.rx_byte;
    assign w_take  = i_rx.valid && i_rx.ready;
    assign w_issue = r_busy && !r_rd_pend && (!r_out_valid || o_ch.ready);
    assign w_off   = r_pos - POS_FIRST_HI;
    assign w_waddr = IDX_W'(w_off >> 1);
    assign w_we    = w_take && r_pos[0] && (r_pos >= POS_FIRST_HI) && (r_pos < POS_CSUML);

    rcsfd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNEL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({w_b, r_lo}),
        .i_re    (w_issue),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_pos    = r_pos;
        n_csum   = r_csum;
        n_lo     = r_lo;
        n_cklo   = r_cklo;
        n_busy   = r_busy;
        n_rd_idx = r_rd_idx;

        if (w_take) begin
            case (r_pos)
                POS_HDR0: begin
                    if (w_b == HDR_FIRST) begin
                        n_csum = CSUM_INIT - WORD_W'(HDR_FIRST);
                        n_pos  = POS_HDR1;
                    end else begin
                        n_csum = CSUM_INIT;
                        n_pos  = POS_HDR0;
                    end
                end
                POS_HDR1: begin
                    if (w_b == HDR_SECOND) begin
                        n_csum = r_csum - WORD_W'(w_b);
                        n_pos  = r_pos + POS_W'(1);
                    end else if (w_b == HDR_FIRST) begin
                        n_csum = CSUM_INIT - WORD_W'(HDR_FIRST);
                        n_pos  = POS_HDR1;
                    end else begin
                        n_csum = CSUM_INIT;
                        n_pos  = POS_HDR0;
                    end
                end
                POS_CSUML: begin
                    n_cklo = w_b;
                    n_pos  = r_pos + POS_W'(1);
                end
                POS_CSUMH: begin
                    if ({w_b, r_cklo} == r_csum) begin
                        n_busy   = 1'b1;
                        n_rd_idx = '0;
                    end
                    n_csum = CSUM_INIT;
                    n_pos  = POS_HDR0;
                end
                default: begin
                    n_csum = r_csum - WORD_W'(w_b);
                    if (!r_pos[0]) begin
                        n_lo = w_b;
                    end
                    n_pos = r_pos + POS_W'(1);
                end
            endcase
        end

        if (w_issue) begin
            n_rd_idx = r_rd_idx + IDX_W'(1);
            if (r_rd_idx == IDX_LAST) begin
                n_busy = 1'b0;
            end
        end

        n_out_valid = r_out_valid;
        if (o_ch.valid && o_ch.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_rd_pend) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HDR0;
            r_csum      <= CSUM_INIT;
            r_lo        <= '0;
            r_cklo      <= '0;
            r_busy      <= 1'b0;
            r_rd_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_csum      <= n_csum;
            r_lo        <= n_lo;
            r_cklo      <= n_cklo;
            r_busy      <= n_busy;
            r_rd_idx    <= n_rd_idx;
            r_rd_pend   <= w_issue;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_pend_idx <= r_rd_idx;
        end
        if (r_rd_pend) begin
            r_out_idx  <= r_pend_idx;
            r_out_val  <= w_rdata;
            r_out_last <= (r_pend_idx == IDX_LAST);
        end
    end

    assign i_rx.ready         = !r_busy;
    assign o_ch.valid         = r_out_valid;
    assign o_ch.channel_index = CH_IDX_W'(r_out_idx);
    assign o_ch.channel_value = r_out_val;
    assign o_ch.last_channel  = r_out_last;

endmodule

>>> sv/rcsfd_ram.sv
module rcsfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
